### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the rtl core. Each macro checks on the rising edge
// of clk and is off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pkt_pkg.sv
// ----------------------------------------------------------------------------
// pkt_pkg
// Shared widths, constants and result codes of the held-key tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkt_pkg;

  // default number of list slots
  localparam int KEY_SLOTS_DEF = 8;

  // field widths
  localparam int RAW_W    = 8;
  localparam int CODE_W   = 7;
  localparam int STATUS_W = 3;
  localparam int HCOUNT_W = 4;
  localparam int SLOT_W   = 3;

  // scancode layout
  localparam int REL_POS = 7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HELD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

endpackage

### rtl/core/pressed_key_set_tracker.sv
// ----------------------------------------------------------------------------
// pressed_key_set_tracker
// Ordered list of held key codes, updated from press/release scancodes
// by a small sequencer that walks one slot memory.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, raw_byte                     | sink
//  out     | out_valid, out_ready, status, held_count, slot,  | source
//          | key_code, error_latched                          |
//
//  Search reads one slot per cycle from the slot memory (registered data). A
//  release then moves each later entry down a slot with one read and one write
//  state. in_ready is high only while idle; a result stalled by out_ready waits
//  in the output register while the next item runs. Reset clears the count and
//  the error flag; slot contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pressed_key_set_tracker #(
  parameter int KEY_SLOTS = pkt_pkg::KEY_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pkt_pkg::RAW_W-1:0]     raw_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pkt_pkg::STATUS_W-1:0]  status,
  output logic [pkt_pkg::HCOUNT_W-1:0]  held_count,
  output logic [pkt_pkg::SLOT_W-1:0]    slot,
  output logic [pkt_pkg::CODE_W-1:0]    key_code,
  output logic                          error_latched
);

  import pkt_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CW = $clog2(KEY_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_CNT = CW'(KEY_SLOTS);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_SHIFT_RD = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic                err;
  logic [CW-1:0]       scan;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic [IW-1:0]       k;
  logic [CODE_W-1:0]   code;
  logic                rel;
  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_slot;

  // slot memory
  logic [CODE_W-1:0] mem [KEY_SLOTS];
  logic [CODE_W-1:0] rd_data;
  logic [IW-1:0]     mem_ra;
  logic [IW-1:0]     mem_wa;
  logic [CODE_W-1:0] mem_wd;
  logic              mem_we;

  logic          hit;
  logic          miss;
  logic          issue;
  logic [CW:0]   k_up;
  logic          shift_more;
  logic          can_add;
  logic          out_load;
  logic [CW+HCOUNT_W-1:0] count_ext;
  logic [IW+SLOT_W-1:0]   slot_ext;

  // search compare and next-read decisions
  assign hit        = (state == S_SEARCH) && cmp_vld && (rd_data == code);
  assign miss       = (state == S_SEARCH) && !cmp_vld && (scan >= count);
  assign issue      = (state == S_SEARCH) && !hit && (scan < count);
  assign k_up       = (CW + 1)'(k) + 1'b1;
  assign shift_more = k_up < {1'b0, count};
  assign can_add    = count < SLOTS_CNT;
  assign in_ready   = (state == S_IDLE);
  assign out_load   = (state == S_FINISH) && (!out_valid || out_ready);
  assign count_ext  = {{HCOUNT_W{1'b0}}, count};
  assign slot_ext   = {{SLOT_W{1'b0}}, res_slot};

  // memory port addressing
  always_comb begin
    mem_ra = scan[IW-1:0];
    mem_we = 1'b0;
    mem_wa = count[IW-1:0];
    mem_wd = code;
    case (state)
      S_SEARCH: begin
        mem_ra = scan[IW-1:0];
        if (miss && !rel && can_add) begin
          mem_we = 1'b1;
          mem_wa = count[IW-1:0];
          mem_wd = code;
        end
      end
      S_SHIFT_RD: begin
        mem_ra = k_up[IW-1:0];
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        mem_wa = k;
        mem_wd = rd_data;
      end
      default: begin
        mem_ra = scan[IW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= 1'b0;
      scan      <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register valid flag
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan    <= '0;
            cmp_vld <= 1'b0;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          cmp_vld <= issue;
          if (issue) begin
            scan <= scan + 1'b1;
          end
          if (hit) begin
            state <= rel ? S_SHIFT_RD : S_FINISH;
          end else if (miss) begin
            if (rel) begin
              err <= 1'b1;
            end else if (can_add) begin
              count <= count + 1'b1;
            end
            state <= S_FINISH;
          end
        end
        S_SHIFT_RD: begin
          if (shift_more) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count - 1'b1;
            state <= S_FINISH;
          end
        end
        S_SHIFT_WR: begin
          state <= S_SHIFT_RD;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      code <= raw_byte[CODE_W-1:0];
      rel  <= raw_byte[REL_POS];
    end
    if (state == S_SEARCH) begin
      cmp_idx <= scan[IW-1:0];
    end
    if (hit) begin
      res_slot   <= cmp_idx;
      k          <= cmp_idx;
      res_status <= rel ? ST_REMOVED : ST_HELD;
    end else if (miss) begin
      if (rel) begin
        res_status <= ST_MISSING;
        res_slot   <= '0;
      end else if (can_add) begin
        res_status <= ST_ADDED;
        res_slot   <= count[IW-1:0];
      end else begin
        res_status <= ST_FULL;
        res_slot   <= '0;
      end
    end
    if (state == S_SHIFT_WR) begin
      k <= k_up[IW-1:0];
    end
    if (out_load) begin
      status        <= res_status;
      held_count    <= count_ext[HCOUNT_W-1:0];
      slot          <= slot_ext[SLOT_W-1:0];
      key_code      <= code;
      error_latched <= err;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, count <= SLOTS_CNT, "held count above slot count")
  `ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready while item in work")
  `ASSERT_SAME(a_out_from_finish, $rose(out_valid), $past(state) == S_FINISH, "result without finish")
  `ASSERT_ALWAYS(a_err_sticky, !$fell(err), "release error flag cleared")

endmodule
